/* hdl/next_fit_slot_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Next-fit slot allocator assertion macros
// Shorthand for clocked implications, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_SLOT_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define NFSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nfsa_pkg.sv */
// ----------------------------------------------------------------------------
// Next-fit slot allocator package
// Shared constants, result codes and controller state encoding.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    // Flags are stored 64 to a memory word
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_SCAN     = 5'b00100,
        S_FREE_CHK = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

endpackage

/* hdl/nfsa_ram.sv */
// ----------------------------------------------------------------------------
// Next-fit slot allocator RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/next_fit_slot_allocator.sv */
// ----------------------------------------------------------------------------
// Next-fit slot allocator
// In-use flags for a fixed pool of slots, with a next-fit search pointer and
// a count of used slots.
// ----------------------------------------------------------------------------
// The in-use flags sit in one RAM of 64-bit words, and an allocate reads one
// word per cycle from the search pointer onward, wrapping once, and visits at
// most ceil(pool/64) + 1 words, so 17 for a 1024-slot pool. One request is in
// flight at a time; a new one is taken while the last result still waits on
// the output. After reset the block clears the RAM, one word per cycle, all
// ceil(MAX_SLOTS/64) words (16 by default), and holds in_stall high meanwhile.
// Write pool_size only while no request is outstanding.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator
    import nfsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    localparam int SLOT_W = $clog2(MAX_SLOTS),
    localparam int CNT_W = $clog2(MAX_SLOTS + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [SLOT_W-1:0] slot_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] granted_slot,
    output logic [CNT_W-1:0]  used_count
);

    localparam int WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SX    = AW + BIT_W;
    localparam int CW    = (SX > CNT_W) ? SX : CNT_W;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  pool_reg, pool_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              out_valid_reg, out_valid_next;

    logic [CW-1:0]     n_reg, n_next;
    logic [SX-1:0]     start_reg, start_next;
    logic [SX-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     iss_word_reg, iss_word_next;
    logic              iss_phase_reg, iss_phase_next;
    logic [AW-1:0]     chk_word_reg, chk_word_next;
    logic              chk_phase_reg, chk_phase_next;
    status_t           res_status_reg, res_status_next;
    logic [SX-1:0]     res_slot_reg, res_slot_next;
    status_t           out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  out_used_reg, out_used_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 in_take;
    logic                 out_take;
    logic                 out_load;
    logic [CW-1:0]        n_eff;
    logic [SX-1:0]        start_eff;
    logic [SX-1:0]        idx_x;
    logic [CW-1:0]        last_slot;
    logic [AW-1:0]        last_word;
    logic [BIT_W-1:0]     last_bit;
    logic [AW-1:0]        start_word;
    logic [BIT_W-1:0]     start_bit;
    logic                 chk_term;
    logic                 iss_term;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_BITS-1:0] hit_onehot;
    logic [BIT_W-1:0]     hit_bit;
    logic [SX-1:0]        hit_slot;
    logic [CW-1:0]        hit_inc;
    logic [WORD_BITS-1:0] idx_onehot;

    nfsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_flags (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign in_take      = in_valid && !in_stall;
    assign out_take     = out_valid_reg && !out_stall;
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign granted_slot = out_slot_reg;
    assign used_count   = out_used_reg;

    // Effective pool size and search start for a new request
    always_comb
    begin
        if (pool_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (pool_reg > CNT_W'(MAX_SLOTS))
        begin
            n_eff = CW'(MAX_SLOTS);
        end
        else
        begin
            n_eff = CW'(pool_reg);
        end
        start_eff = (CW'(ptr_reg) < n_eff) ? SX'(ptr_reg) : '0;
        idx_x     = SX'(slot_index);
    end

    assign last_slot  = n_reg - CW'(1);
    assign last_word  = last_slot[SX-1:BIT_W];
    assign last_bit   = last_slot[BIT_W-1:0];
    assign start_word = start_reg[SX-1:BIT_W];
    assign start_bit  = start_reg[BIT_W-1:0];

    // Phase 0 runs from the start word to the last word, phase 1 wraps from
    // word 0 back to the start word; with a zero start phase 1 is skipped.
    assign chk_term = chk_phase_reg ? (chk_word_reg == start_word)
                                    : ((chk_word_reg == last_word) && (start_reg == '0));
    assign iss_term = iss_phase_reg ? (iss_word_reg == start_word)
                                    : ((iss_word_reg == last_word) && (start_reg == '0));

    // Candidate bits of the word under test
    always_comb
    begin
        logic [WORD_BITS-1:0] lo_m;
        logic [WORD_BITS-1:0] hi_m;
        lo_m = ONES;
        hi_m = ONES;
        if (!chk_phase_reg)
        begin
            if (chk_word_reg == start_word)
            begin
                lo_m = ONES << start_bit;
            end
            if (chk_word_reg == last_word)
            begin
                hi_m = ONES >> (BIT_W'(WORD_BITS - 1) - last_bit);
            end
        end
        else if (chk_word_reg == start_word)
        begin
            lo_m = ~(ONES << start_bit);
        end
        scan_mask = lo_m & hi_m;
    end

    assign free_vec   = ~ram_rdata & scan_mask;
    assign hit_onehot = free_vec & (~free_vec + WORD_BITS'(1));

    always_comb
    begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                hit_bit = BIT_W'(i);
            end
        end
    end

    assign hit_slot   = {chk_word_reg, hit_bit};
    assign hit_inc    = CW'(hit_slot) + CW'(1);
    assign idx_onehot = WORD_BITS'(1) << idx_reg[BIT_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        pool_next       = pool_reg;
        ptr_next        = ptr_reg;
        used_next       = used_reg;
        chk_vld_next    = chk_vld_reg;
        out_valid_next  = out_valid_reg;
        n_next          = n_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        iss_word_next   = iss_word_reg;
        iss_phase_next  = iss_phase_reg;
        chk_word_next   = chk_word_reg;
        chk_phase_next  = chk_phase_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_used_next   = out_used_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_word_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = iss_word_reg;

        if (cfg_we)
        begin
            pool_next = cfg_wdata;
        end

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_take)
                begin
                    n_next         = n_eff;
                    start_next     = start_eff;
                    idx_next       = idx_x;
                    iss_word_next  = start_eff[SX-1:BIT_W];
                    iss_phase_next = 1'b0;
                    chk_vld_next   = 1'b0;
                    if (kind)
                    begin
                        // fetch the flag word now, range is checked next cycle
                        ram_re     = (CW'(idx_x) < n_eff);
                        ram_raddr  = idx_x[SX-1:BIT_W];
                        state_next = S_FREE_CHK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one word ahead of the one being tested
                ram_re         = 1'b1;
                ram_raddr      = iss_word_reg;
                chk_word_next  = iss_word_reg;
                chk_phase_next = iss_phase_reg;
                chk_vld_next   = 1'b1;
                if (!iss_term)
                begin
                    if (!iss_phase_reg && (iss_word_reg == last_word))
                    begin
                        iss_word_next  = '0;
                        iss_phase_next = 1'b1;
                    end
                    else
                    begin
                        iss_word_next = iss_word_reg + AW'(1);
                    end
                end

                if (chk_vld_reg)
                begin
                    if (free_vec != '0)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = chk_word_reg;
                        ram_wdata       = ram_rdata | hit_onehot;
                        used_next       = used_reg + CNT_W'(1);
                        ptr_next        = (hit_inc >= n_reg) ? '0 : hit_inc[SLOT_W-1:0];
                        res_status_next = ST_OK;
                        res_slot_next   = hit_slot;
                        state_next      = S_DONE;
                    end
                    else if (chk_term)
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_FREE_CHK:
            begin
                res_slot_next = '0;
                state_next    = S_DONE;
                if (CW'(idx_reg) >= n_reg)
                begin
                    res_status_next = ST_RANGE;
                end
                else if ((ram_rdata & idx_onehot) == '0)
                begin
                    res_status_next = ST_FREE;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = idx_reg[SX-1:BIT_W];
                    ram_wdata       = ram_rdata & ~idx_onehot;
                    res_status_next = ST_OK;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - CNT_W'(1);
                    end
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg[SLOT_W-1:0];
                    out_used_next   = used_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pool_reg      <= CNT_W'(MAX_SLOTS);
            ptr_reg       <= '0;
            used_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pool_reg      <= pool_next;
            ptr_reg       <= ptr_next;
            used_reg      <= used_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        start_reg      <= start_next;
        idx_reg        <= idx_next;
        iss_word_reg   <= iss_word_next;
        iss_phase_reg  <= iss_phase_next;
        chk_word_reg   <= chk_word_next;
        chk_phase_reg  <= chk_phase_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_used_reg   <= out_used_next;
    end

endmodule

/* hdl/nfsa_checker.sv */
// ----------------------------------------------------------------------------
// Next-fit slot allocator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "next_fit_slot_allocator_macros.svh"

module nfsa_checker
    import nfsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    localparam int SLOT_W = $clog2(MAX_SLOTS),
    localparam int CNT_W = $clog2(MAX_SLOTS + 1)
)(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [SLOT_W-1:0] granted_slot,
    input logic [CNT_W-1:0]  used_count
);

    // a stalled result word stays put
    `NFSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(granted_slot) && $stable(used_count),
        "stalled result word changed")

    `NFSA_ASSERT_IMP(a_grant_zero, out_valid && (status != ST_OK), granted_slot == '0,
        "granted slot not zero on a failed request")

    // a full pool has at least one slot in use
    `NFSA_ASSERT_IMP(a_full_count, out_valid && (status == ST_FULL), used_count != '0,
        "pool full reported with zero used slots")

    `NFSA_ASSERT_IMP(a_count_cap, out_valid, used_count <= CNT_W'(MAX_SLOTS),
        "used count above capacity")

endmodule

bind next_fit_slot_allocator nfsa_checker #(.MAX_SLOTS(MAX_SLOTS)) u_nfsa_checker (.*);
